// ----- design/bpc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; used by every module in the design folder.
`timescale 1ns / 1ps

package bpc_pkg;

	// Fixed arithmetic constants
	localparam int TEMP_REF       = 2000; // 20.00 degrees
	localparam int TEMP_SHIFT     = 23;   // dT*C6 / 2^23
	localparam int OFF_SHIFT      = 7;    // C4*dT / 2^7
	localparam int SENS_SHIFT     = 8;    // C3*dT / 2^8
	localparam int T2_SHIFT       = 31;   // dT^2 >> 31
	localparam int P_SENS_SHIFT   = 21;   // D1*SENS / 2^21
	localparam int P_OUT_SHIFT    = 15;   // (...) / 2^15
	localparam int SENS_SPLIT     = 20;   // low part width of split multiply

	// Internal widths
	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int DT_W    = 25;
	localparam int MT_W    = 42;  // dT times a calibration word
	localparam int DD_W    = 48;  // dT squared, non-negative
	localparam int Q_W     = 18;  // dT*C6 / 2^23
	localparam int TEMP_W  = 19;
	localparam int T2_W    = 17;
	localparam int AUX_W   = 35;  // (TEMP-2000)^2
	localparam int ACC_W   = 40;  // OFF and SENS
	localparam int PROD_W  = 64;  // D1 * SENS
	localparam int X_W     = 48;  // D1*SENS/2^21 - OFF
	localparam int PRES_W  = 32;
	localparam int HI_W    = ACC_W - SENS_SPLIT;  // high part of SENS in split multiply

	// Calibration register indexes
	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} cal_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] c1_pressure_sensitivity;
		logic [CAL_W-1:0] c2_pressure_offset;
		logic [CAL_W-1:0] c3_sensitivity_temp_coef;
		logic [CAL_W-1:0] c4_offset_temp_coef;
		logic [CAL_W-1:0] c5_reference_temperature;
		logic [CAL_W-1:0] c6_temperature_coef;
	} cal_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centideg;
		logic signed [PRES_W-1:0] pressure_centimbar;
	} result_t;

	// Handoff from the temperature front end to the pressure back end
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [ACC_W-1:0]  off;
		logic signed [ACC_W-1:0]  sens;
		logic [RAW_W-1:0]         d1;
	} front_t;

endpackage

// ----- design/bpc_front.sv -----
// Front end: dT, first-order TEMP/OFF/SENS and the cold correction, five stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bpc_pkg::sample_t in_data,
	input  bpc_pkg::cal_t    cal,
	output logic             out_valid,
	input  logic             out_ready,
	output bpc_pkg::front_t  out_data
);
	import bpc_pkg::*;

	// Stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// S1: dT = D2 - C5*256
	logic signed [DT_W-1:0] dt_c, dt_s1;
	logic [RAW_W-1:0]       d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;

	assign dt_c = $signed({1'b0, in_data.raw_temperature})
		- $signed({1'b0, cal.c5_reference_temperature, 8'b0});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dt_s1 <= dt_c;
			d1_s1 <= in_data.raw_pressure;
		end
	end

	// S2: the four products of dT
	logic signed [CAL_W:0]     c3_x, c4_x, c6_x;
	logic signed [MT_W-1:0]    pt_c, po_c, ps_c, pt_s2, po_s2, ps_s2;
	logic signed [2*DT_W-1:0]  dd_c;
	logic [DD_W-1:0]           dd_s2;

	assign c3_x = $signed({1'b0, cal.c3_sensitivity_temp_coef});
	assign c4_x = $signed({1'b0, cal.c4_offset_temp_coef});
	assign c6_x = $signed({1'b0, cal.c6_temperature_coef});
	assign pt_c = dt_s1 * c6_x;
	assign po_c = dt_s1 * c4_x;
	assign ps_c = dt_s1 * c3_x;
	assign dd_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pt_s2 <= pt_c;
			po_s2 <= po_c;
			ps_s2 <= ps_c;
			dd_s2 <= dd_c[DD_W-1:0];
			d1_s2 <= d1_s1;
		end
	end

	// S3: truncating divides, first-order TEMP/OFF/SENS
	logic signed [MT_W-1:0]   pt_b, po_b, ps_b, pt_q, po_q, ps_q;
	logic signed [Q_W-1:0]    q_c, q_s3;
	logic signed [TEMP_W-1:0] temp0_c, temp0_s3, temp0_s4;
	logic signed [ACC_W-1:0]  off0_c, sens0_c, off0_s3, sens0_s3, off0_s4, sens0_s4;
	logic [T2_W-1:0]          t2_s3, t2_s4;
	logic                     cold_s3, cold_s4, cold_s5;

	// bias negative values so the arithmetic shift rounds toward zero
	assign pt_b = pt_s2 + $signed({{(MT_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{pt_s2[MT_W-1]}}});
	assign po_b = po_s2 + $signed({{(MT_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{po_s2[MT_W-1]}}});
	assign ps_b = ps_s2 + $signed({{(MT_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{ps_s2[MT_W-1]}}});
	assign pt_q = pt_b >>> TEMP_SHIFT;
	assign po_q = po_b >>> OFF_SHIFT;
	assign ps_q = ps_b >>> SENS_SHIFT;

	assign q_c     = pt_q[Q_W-1:0];
	assign temp0_c = TEMP_W'(q_c) + TEMP_W'(TEMP_REF);
	assign off0_c  = $signed({8'b0, cal.c2_pressure_offset, 16'b0}) + po_q[ACC_W-1:0];
	assign sens0_c = $signed({9'b0, cal.c1_pressure_sensitivity, 15'b0}) + ps_q[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q_s3     <= q_c;
			temp0_s3 <= temp0_c;
			off0_s3  <= off0_c;
			sens0_s3 <= sens0_c;
			t2_s3    <= dd_s2[DD_W-1:T2_SHIFT];
			cold_s3  <= q_c[Q_W-1];
			d1_s3    <= d1_s2;
		end
	end

	// S4: (TEMP - 2000)^2
	logic signed [2*Q_W-1:0] sq_c;
	logic [AUX_W-1:0]        aux_s4;

	assign sq_c = q_s3 * q_s3;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			aux_s4   <= sq_c[AUX_W-1:0];
			temp0_s4 <= temp0_s3;
			off0_s4  <= off0_s3;
			sens0_s4 <= sens0_s3;
			t2_s4    <= t2_s3;
			cold_s4  <= cold_s3;
			d1_s4    <= d1_s3;
		end
	end

	// S5: second-order correction below 20.00 degrees
	logic [AUX_W+1:0]         five_c;
	logic [AUX_W:0]           off2_c;
	logic [AUX_W-1:0]         sens2_c;
	logic signed [ACC_W-1:0]  off_c, sens_c, off_s5, sens_s5;
	logic signed [TEMP_W-1:0] temp_c, temp_s5;

	assign five_c  = {2'b0, aux_s4} + {aux_s4, 2'b0};
	assign off2_c  = five_c[AUX_W+1:1];
	assign sens2_c = five_c[AUX_W+1:2];
	assign off_c   = off0_s4 - (cold_s4 ? $signed({4'b0, off2_c}) : '0);
	assign sens_c  = sens0_s4 - (cold_s4 ? $signed({5'b0, sens2_c}) : '0);
	assign temp_c  = temp0_s4 - (cold_s4 ? $signed({2'b0, t2_s4}) : '0);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			temp_s5 <= temp_c;
			off_s5  <= off_c;
			sens_s5 <= sens_c;
			cold_s5 <= cold_s4;
			d1_s5   <= d1_s4;
		end
	end

	assign out_valid     = v_s5;
	assign out_data.temp = temp_s5;
	assign out_data.off  = off_s5;
	assign out_data.sens = sens_s5;
	assign out_data.d1   = d1_s5;

	// Corrected items always stay below the reference temperature
	a_cold_below_ref: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && cold_s5 |-> temp_s5 < TEMP_W'(TEMP_REF))
		else $error("cold item above reference temperature");

	// Backpressure only reaches the input when every stage holds an item
	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready)
		else $error("input stalled with a bubble in the pipeline");

	// A stalled last stage keeps its item
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5 && $stable(temp_s5) && $stable(off_s5)
			&& $stable(sens_s5) && $stable(d1_s5))
		else $error("stalled stage 5 item changed");

endmodule

// ----- design/bpc_press.sv -----
// Back end: pressure P = (D1*SENS/2^21 - OFF)/2^15 over four stages.
// Depends on bpc_pkg; fed by bpc_front.
`timescale 1ns / 1ps

module bpc_press (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bpc_pkg::front_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bpc_pkg::result_t out_data
);
	import bpc_pkg::*;

	// Stage valids and enables
	logic v_s6, v_s7, v_s8, v_s9;
	logic en_s6, en_s7, en_s8, en_s9;

	assign en_s9    = !v_s9 || out_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// S6: D1*SENS split into high (signed) and low (unsigned) partial products
	logic signed [RAW_W:0]          d1_x;
	logic signed [HI_W-1:0]         sens_hi;
	logic signed [RAW_W+HI_W:0]     mh_c, mh_s6;
	logic [RAW_W+SENS_SPLIT-1:0]    ml_c, ml_s6;
	logic signed [ACC_W-1:0]        off_s6, off_s7;
	logic signed [TEMP_W-1:0]       temp_s6, temp_s7, temp_s8, temp_s9;

	assign d1_x    = $signed({1'b0, in_data.d1});
	assign sens_hi = in_data.sens[ACC_W-1:SENS_SPLIT];
	assign mh_c    = d1_x * sens_hi;
	assign ml_c    = in_data.d1 * in_data.sens[SENS_SPLIT-1:0];

	always_ff @(posedge clk) begin
		if (en_s6) begin
			mh_s6   <= mh_c;
			ml_s6   <= ml_c;
			off_s6  <= in_data.off;
			temp_s6 <= in_data.temp;
		end
	end

	// S7: recombine partial products
	logic signed [PROD_W-1:0] prod_c, prod_s7;

	assign prod_c = (PROD_W'(mh_s6) <<< SENS_SPLIT)
		+ $signed({{(PROD_W-RAW_W-SENS_SPLIT){1'b0}}, ml_s6});

	always_ff @(posedge clk) begin
		if (en_s7) begin
			prod_s7 <= prod_c;
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	// S8: truncating divide by 2^21, minus OFF
	logic signed [PROD_W-1:0] prod_b, prod_q;
	logic signed [X_W-1:0]    x_c, x_s8;

	assign prod_b = prod_s7
		+ $signed({{(PROD_W-P_SENS_SHIFT){1'b0}}, {P_SENS_SHIFT{prod_s7[PROD_W-1]}}});
	assign prod_q = prod_b >>> P_SENS_SHIFT;
	assign x_c    = prod_q[X_W-1:0] - X_W'(off_s7);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			x_s8    <= x_c;
			temp_s8 <= temp_s7;
		end
	end

	// S9: truncating divide by 2^15, keep low 32 bits
	logic signed [X_W-1:0]    x_b, x_q;
	logic signed [PRES_W-1:0] pres_s9;

	assign x_b = x_s8 + $signed({{(X_W-P_OUT_SHIFT){1'b0}}, {P_OUT_SHIFT{x_s8[X_W-1]}}});
	assign x_q = x_b >>> P_OUT_SHIFT;

	always_ff @(posedge clk) begin
		if (en_s9) begin
			pres_s9 <= x_q[PRES_W-1:0];
			temp_s9 <= temp_s8;
		end
	end

	assign out_valid                     = v_s9;
	assign out_data.temperature_centideg = temp_s9;
	assign out_data.pressure_centimbar   = pres_s9;

endmodule

// ----- design/baro_pressure_temp_compensation.sv -----
// Throughput: one request per cycle; a stall on the result side backs up
// stage by stage, so bubbles are squeezed out before the input stalls.
// Reset (arst_n low) empties the pipeline and clears all six calibration
// registers to zero; no clearing pass is needed.
// Top level: calibration registers plus front and pressure pipelines.
// Depends on bpc_pkg, bpc_front and bpc_press.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [2:0]       wr_idx,
	input  logic [15:0]      wr_data,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  bpc_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output bpc_pkg::result_t result
);
	import bpc_pkg::*;

	// Calibration registers
	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (cal_idx_t'(wr_idx))
				REG_C1:  cal_q.c1_pressure_sensitivity  <= wr_data;
				REG_C2:  cal_q.c2_pressure_offset       <= wr_data;
				REG_C3:  cal_q.c3_sensitivity_temp_coef <= wr_data;
				REG_C4:  cal_q.c4_offset_temp_coef      <= wr_data;
				REG_C5:  cal_q.c5_reference_temperature <= wr_data;
				REG_C6:  cal_q.c6_temperature_coef      <= wr_data;
				default: ;
			endcase
		end
	end

	// Pipeline halves
	logic   mid_valid, mid_ready;
	front_t mid_data;

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (sample_ready),
		.in_data   (sample),
		.cal       (cal_q),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	bpc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

endmodule
